[hdl/crtm_pkg.sv]
// Shared types and constants for the climb rate tone mapper.
// Used by crtm_front, crtm_queue, crtm_back and climb_rate_tone_mapper.
`default_nettype none

package crtm_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 16;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_SET_ONE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_TOGGLE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_MUTE       = 3'd0,
    OP_UNMUTE     = 3'd1,
    OP_BEEP       = 3'd2,
    OP_SHORT_BEEP = 3'd3,
    OP_CONTINUOUS = 3'd4,
    OP_FREQUENCY  = 3'd5,
    OP_PERIOD     = 3'd6
  } sound_op_t;

  typedef enum logic [2:0] {
    REG_CLIMB_GAIN      = 3'd0,
    REG_CLIMB_INTERCEPT = 3'd1,
    REG_LEVEL_GAIN      = 3'd2,
    REG_LEVEL_INTERCEPT = 3'd3,
    REG_SINK_GAIN       = 3'd4,
    REG_SINK_INTERCEPT  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_MUTE  = 2'd0,
    KIND_CLIMB = 2'd1,
    KIND_LEVEL = 2'd2,
    KIND_SINK  = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [15:0] climb_rate;
  } crtm_item_t;

  typedef struct packed {
    sound_op_t   sound_op;
    logic [15:0] sound_value;
    logic        last;
  } crtm_sound_t;

  // One classified sample: case, intercept*100 + gain*c, and the beep period
  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] num;
    logic [6:0]         period;
  } crtm_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } crtm_qstat_t;

  // Register reset values
  localparam logic [11:0]        CLIMB_GAIN_RST      = 12'd300;
  localparam logic signed [15:0] CLIMB_INTERCEPT_RST = 16'sd600;
  localparam logic [11:0]        LEVEL_GAIN_RST      = 12'd200;
  localparam logic signed [15:0] LEVEL_INTERCEPT_RST = 16'sd500;
  localparam logic [11:0]        SINK_GAIN_RST       = 12'd100;
  localparam logic signed [15:0] SINK_INTERCEPT_RST  = 16'sd700;
  localparam logic [1:0]         MODE_RST            = 2'd2;
  localparam logic [1:0]         MODE_ONE            = 2'd1;
  localparam logic [1:0]         MODE_ZERO           = 2'd0;
  localparam logic [1:0]         MODE_FULL           = 2'd3;

  // Climb rate limits and case thresholds, cm/s
  localparam logic signed [15:0] CLAMP_HI  = 16'sd500;
  localparam logic signed [15:0] CLAMP_LO  = -16'sd400;
  localparam logic signed [9:0]  CLIMB_MIN = 10'sd20;
  localparam logic signed [9:0]  LEVEL_MIN = -10'sd100;
  localparam logic signed [9:0]  SINK_MAX  = -10'sd200;

  // Period = 100 - ceil(4*t/25) = 100 - floor((4*t + 24) * 2622 / 2^16)
  localparam logic signed [9:0]  PERIOD_RATE_MIN = 10'sd100;
  localparam logic [8:0]         PERIOD_RATE_DEF = 9'd100;
  localparam logic [10:0]        PERIOD_BIAS     = 11'd24;
  localparam logic [22:0]        PERIOD_RECIP    = 23'd2622;
  localparam logic [6:0]         PERIOD_BASE     = 7'd100;

  // Frequency: num / 100 as (num * ceil(2^30/100)) >> 30, exact below 2^23
  localparam logic signed [23:0] CENT       = 24'sd100;
  localparam logic [46:0]        FREQ_RECIP = 47'd10737419;
  localparam int                 FREQ_SHIFT = 30;
  localparam logic signed [23:0] FREQ_SAT   = 24'sd6553600;
  localparam logic [15:0]        FREQ_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

[hdl/climb_rate_tone_mapper.sv]
// Climb rate tone mapper, top level. Instantiates crtm_front, crtm_queue
// and crtm_back; depends on crtm_pkg.
//
// Each input beat is a mode command (set, clear, toggle; no result) or a
// climb rate sample, which yields one to four sound command beats: four
// for climb and level, three for sink, one for mute, the final one flagged
// by last. The front end takes a beat in every cycle it is not stalled; a
// sample passes registers s1 and s2 before it is pushed into the queue. The
// back end drains the queue and emits one sound beat per cycle, unless
// snd_stall holds it, through its output register, so the sustained rate
// is set by that single output port and the beats per sample. The first
// beat of a sample leaves through s1, s2, the queue and the work and snd registers.
// cfg_ready is always high; write registers only while idle.
`default_nettype none

module climb_rate_tone_mapper #(
  parameter int QUEUE_DEPTH = crtm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  crtm_pkg::crtm_item_t  item,
  output logic                  snd_valid,
  input  logic                  snd_stall,
  output crtm_pkg::crtm_sound_t snd,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [crtm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crtm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import crtm_pkg::*;

  logic        push;
  crtm_entry_t push_entry;
  logic        pop;
  crtm_entry_t head;
  crtm_qstat_t qstat;

  crtm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_entry (push_entry),
    .qstat      (qstat)
  );

  crtm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  crtm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .snd_valid (snd_valid),
    .snd_stall (snd_stall),
    .snd       (snd)
  );

endmodule

`default_nettype wire

[hdl/crtm_front.sv]
// Front end: configuration registers, tone mode, clamp and case selection,
// the product intercept*100 + gain*c, and the beep period. Depends on crtm_pkg.
`default_nettype none

module crtm_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  crtm_pkg::crtm_item_t   item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [crtm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crtm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                   push,
  output crtm_pkg::crtm_entry_t  push_entry,
  input  crtm_pkg::crtm_qstat_t  qstat
);
  import crtm_pkg::*;

  logic [11:0]        climb_gain;
  logic signed [15:0] climb_intercept;
  logic [11:0]        level_gain;
  logic signed [15:0] level_intercept;
  logic [11:0]        sink_gain;
  logic signed [15:0] sink_intercept;
  logic [1:0]         tone_mode;

  logic               s1_valid;
  kind_t              s1_kind;
  logic signed [9:0]  s1_c;
  logic [11:0]        s1_gain;
  logic signed [15:0] s1_intercept;

  logic               s2_valid;
  crtm_entry_t        s2_entry;

  logic               item_fire;
  logic               s1_take;
  logic               s2_take;
  logic signed [15:0] rate_clamped;
  logic signed [9:0]  c;
  kind_t              kind;
  logic [11:0]        gain_sel;
  logic signed [15:0] intercept_sel;

  logic signed [12:0] gain_s;
  logic signed [23:0] gain_prod;
  logic signed [23:0] intercept_x100;
  logic [8:0]         period_rate;
  logic [10:0]        period_arg;
  logic [22:0]        period_prod;
  crtm_entry_t        entry_next;

  assign cfg_ready  = 1'b1;
  assign push       = s2_valid && !qstat.full;
  assign push_entry = s2_entry;
  assign s2_take    = !s2_valid || push;
  assign s1_take    = !s1_valid || s2_take;
  assign item_stall = !s1_take;
  assign item_fire  = item_valid && !item_stall;

  // Clamp and classify
  always_comb begin
    if (item.climb_rate > CLAMP_HI) begin
      rate_clamped = CLAMP_HI;
    end else if (item.climb_rate < CLAMP_LO) begin
      rate_clamped = CLAMP_LO;
    end else begin
      rate_clamped = item.climb_rate;
    end
    c = signed'(rate_clamped[9:0]);

    kind          = KIND_MUTE;
    gain_sel      = climb_gain;
    intercept_sel = climb_intercept;
    if (c > CLIMB_MIN && tone_mode != MODE_ZERO) begin
      kind = KIND_CLIMB;
    end else if (c > LEVEL_MIN && tone_mode == MODE_FULL) begin
      kind          = KIND_LEVEL;
      gain_sel      = level_gain;
      intercept_sel = level_intercept;
    end else if (c <= SINK_MAX && tone_mode >= MODE_RST) begin
      kind          = KIND_SINK;
      gain_sel      = sink_gain;
      intercept_sel = sink_intercept;
    end
  end

  // Frequency numerator and beep period
  always_comb begin
    gain_s         = signed'({1'b0, s1_gain});
    gain_prod      = 24'(gain_s) * 24'(s1_c);
    intercept_x100 = 24'(s1_intercept) * CENT;
    if (s1_c > PERIOD_RATE_MIN) begin
      period_rate = s1_c[8:0];
    end else begin
      period_rate = PERIOD_RATE_DEF;
    end
    period_arg  = {period_rate, 2'b00} + PERIOD_BIAS;
    period_prod = 23'(period_arg) * PERIOD_RECIP;

    entry_next.kind   = s1_kind;
    entry_next.num    = gain_prod + intercept_x100;
    entry_next.period = PERIOD_BASE - period_prod[22:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      climb_gain      <= CLIMB_GAIN_RST;
      climb_intercept <= CLIMB_INTERCEPT_RST;
      level_gain      <= LEVEL_GAIN_RST;
      level_intercept <= LEVEL_INTERCEPT_RST;
      sink_gain       <= SINK_GAIN_RST;
      sink_intercept  <= SINK_INTERCEPT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_CLIMB_GAIN:      climb_gain      <= cfg_data[11:0];
        REG_CLIMB_INTERCEPT: climb_intercept <= signed'(cfg_data);
        REG_LEVEL_GAIN:      level_gain      <= cfg_data[11:0];
        REG_LEVEL_INTERCEPT: level_intercept <= signed'(cfg_data);
        REG_SINK_GAIN:       sink_gain       <= cfg_data[11:0];
        REG_SINK_INTERCEPT:  sink_intercept  <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_mode <= MODE_RST;
    end else if (item_fire) begin
      case (item.command)
        CMD_SET_ONE: tone_mode <= MODE_ONE;
        CMD_CLEAR:   tone_mode <= MODE_ZERO;
        CMD_TOGGLE:  tone_mode <= tone_mode + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= item_fire && item.command == CMD_SAMPLE;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_kind      <= kind;
      s1_c         <= c;
      s1_gain      <= gain_sel;
      s1_intercept <= intercept_sel;
    end
    if (s2_take) begin
      s2_entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

[hdl/crtm_queue.sv]
// Short queue of classified samples between front and back end.
// Depends on crtm_pkg.
`default_nettype none

module crtm_queue #(
  parameter int DEPTH = crtm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  crtm_pkg::crtm_entry_t push_entry,
  input  logic                  pop,
  output crtm_pkg::crtm_entry_t head,
  output crtm_pkg::crtm_qstat_t qstat
);
  import crtm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crtm_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = count == CNT_W'(DEPTH);
  assign qstat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && qstat.full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && qstat.empty))
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

[hdl/crtm_back.sv]
// Back end: takes one classified sample at a time, divides out the frequency and
// sends sound commands, one beat per cycle unless stalled. Depends on crtm_pkg.
`default_nettype none

module crtm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  crtm_pkg::crtm_entry_t head,
  input  crtm_pkg::crtm_qstat_t qstat,
  output logic                  pop,
  output logic                  snd_valid,
  input  logic                  snd_stall,
  output crtm_pkg::crtm_sound_t snd
);
  import crtm_pkg::*;

  logic        busy;
  logic [1:0]  step;
  crtm_entry_t work;
  logic [15:0] quot;

  logic        fire;
  logic        is_last;
  logic        load;
  logic [46:0] quot_prod;
  logic [15:0] freq;
  crtm_sound_t beat;

  assign fire = busy && (!snd_valid || !snd_stall);
  assign load = (!busy || (fire && is_last)) && !qstat.empty;
  assign pop  = load;

  // Quotient tracks the loaded sample through the quot register; it is ready
  // well before the frequency beat goes out
  assign quot_prod = 47'(work.num[22:0]) * FREQ_RECIP;

  always_comb begin
    if (work.num < 0) begin
      freq = '0;
    end else if (work.num >= FREQ_SAT) begin
      freq = FREQ_MAX;
    end else begin
      freq = quot;
    end
  end

  always_comb begin
    case (work.kind)
      KIND_MUTE: is_last = step == 2'd0;
      KIND_SINK: is_last = step == 2'd2;
      default:   is_last = step == 2'd3;
    endcase
  end

  always_comb begin
    beat.sound_op    = OP_MUTE;
    beat.sound_value = '0;
    beat.last        = is_last;
    if (work.kind != KIND_MUTE) begin
      case (step)
        2'd0: beat.sound_op = OP_UNMUTE;
        2'd1: begin
          case (work.kind)
            KIND_CLIMB: beat.sound_op = OP_BEEP;
            KIND_LEVEL: beat.sound_op = OP_SHORT_BEEP;
            default:    beat.sound_op = OP_CONTINUOUS;
          endcase
        end
        2'd2: begin
          beat.sound_op    = OP_FREQUENCY;
          beat.sound_value = freq;
        end
        default: begin
          beat.sound_op    = OP_PERIOD;
          beat.sound_value = {9'd0, work.period};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      snd_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        step <= '0;
      end else begin
        if (fire && is_last) begin
          busy <= 1'b0;
        end
        if (fire) begin
          step <= step + 2'd1;
        end
      end
      if (fire) begin
        snd_valid <= 1'b1;
      end else if (!snd_stall) begin
        snd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= head;
    end
    quot <= quot_prod[FREQ_SHIFT+15:FREQ_SHIFT];
    if (fire) begin
      snd <= beat;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (busy && work.kind == KIND_MUTE) |-> step == 2'd0)
    else $error("mute sample past its only beat");
  assert property (@(posedge clk) disable iff (rst)
    (busy && work.kind == KIND_SINK) |-> step != 2'd3)
    else $error("sink sample past its third beat");
  assert property (@(posedge clk) disable iff (rst)
    (fire && is_last && qstat.empty) |=> !busy)
    else $error("back end stays busy with nothing loaded");

endmodule

`default_nettype wire
